// ===== src/olte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ordered list table engine.
// No dependencies.
package olte_pkg;

    localparam int POS_W = 6;
    localparam int CAP_W = 7;
    localparam int VAL_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_EDIT   = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_SEARCH = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_EDIT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
    } cell_ctl_t;

    typedef struct packed {
        logic [2:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } olte_in_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic [POS_W-1:0]        found_position;
        logic [CAP_W-1:0]        element_count;
        logic                    is_empty;
        logic                    is_full;
    } olte_out_t;

endpackage

// ===== src/olte_cell.sv =====
`timescale 1ns / 1ps
// One list entry cell: holds a word, shifts to and from its neighbors, compares to the key.
// Depends on olte_pkg.
module olte_cell
    import olte_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int CNT_W      = 7,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] lower,
    input  logic [DATA_WIDTH-1:0] upper,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match,
    output logic                  hit
);

    localparam logic [31:0] IDX_L = 32'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  at_pos;
    logic                  above_pos;
    logic                  at_count;
    logic                  below_count;

    assign at_pos      = 32'(ctl.pos) == IDX_L;
    assign above_pos   = 32'(ctl.pos) < IDX_L;
    assign at_count    = 32'(count) == IDX_L;
    assign below_count = IDX_L < 32'(count);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_APPEND:
            begin
                if (at_count)
                    entry_next = key;
            end
            CELL_INSERT:
            begin
                if (at_pos)
                    entry_next = key;
                else if (above_pos)
                    entry_next = lower;
            end
            CELL_EDIT:
            begin
                if (at_pos)
                    entry_next = key;
            end
            CELL_DELETE:
            begin
                if (at_pos || above_pos)
                    entry_next = upper;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data  = entry_reg;
    assign match = below_count && (entry_reg == key);
    assign hit   = at_pos;

endmodule

// ===== src/ordered_list_table_engine.sv =====
`timescale 1ns / 1ps
// Result: a command accepted from S_IDLE or S_RESP moves through S_EXEC to S_RESP, where done is high for one cycle.
// Commands are refused while busy in S_EXEC; the next command is taken in S_RESP while done shows a result
// set by one update pass across the cell row followed by the search encode.
// Reset: list empty, capacity 64; entry words are not cleared and need no clearing pass.
// The result has no back-pressure: done is held for exactly one cycle.
module ordered_list_table_engine
    import olte_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  olte_in_t    item,
    output logic        done,
    output olte_out_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic [2:0]            cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CAP_W-1:0]      cap_reg;
    status_t               status_reg;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] rd_reg;
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [DEPTH-1:0]      match_reg;

    logic                  accept;
    logic                  cfg_write;
    logic [63:0]           val_wide;
    logic [31:0]           cap32;
    logic [31:0]           eff_cap;
    logic [31:0]           cnt32;
    logic [31:0]           pos32;
    logic                  list_full;
    logic                  read_ok;
    logic                  search_en;
    cell_ctl_t             ctl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      match_vec;
    logic [DEPTH-1:0]      hit_vec;

    logic [DEPTH-1:0]      first_hit;
    logic [IDX_W-1:0]      fpos;
    logic [63:0]           rd_wide;
    logic [63:0]           fpos_wide;
    logic [63:0]           cnt_wide;

    assign accept    = start && !busy;
    assign busy      = state_reg == S_EXEC;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : 32'd0;
    assign val_wide  = 64'(item.value[VAL_W-1:0]);

    // clamp capacity to 1 .. DEPTH
    assign cap32     = 32'(cap_reg);
    assign eff_cap   = (cap32 == 32'd0) ? 32'd1 :
                       (cap32 > 32'(DEPTH)) ? 32'(DEPTH) : cap32;
    assign cnt32     = 32'(count_reg);
    assign pos32     = 32'(pos_reg);
    assign list_full = cnt32 >= eff_cap;

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        read_ok     = 1'b0;
        search_en   = 1'b0;
        ctl.op      = CELL_HOLD;
        ctl.pos     = pos_reg;
        if (state_reg == S_EXEC)
        begin
            case (cmd_reg)
                CMD_APPEND:
                begin
                    if (list_full)
                        status_next = ST_OVERFLOW;
                    else
                    begin
                        ctl.op     = CELL_APPEND;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_INSERT:
                begin
                    if (list_full)
                        status_next = ST_OVERFLOW;
                    else if (pos32 > cnt32)
                        status_next = ST_BAD_INDEX;
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_EDIT:
                begin
                    if (pos32 >= cnt32)
                        status_next = ST_BAD_INDEX;
                    else
                        ctl.op = CELL_EDIT;
                end
                CMD_DELETE:
                begin
                    if (cnt32 == 32'd0)
                        status_next = ST_UNDERFLOW;
                    else if (pos32 >= cnt32)
                        status_next = ST_BAD_INDEX;
                    else
                    begin
                        ctl.op     = CELL_DELETE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_READ:
                begin
                    if (pos32 >= cnt32)
                        status_next = ST_BAD_INDEX;
                    else
                        read_ok = 1'b1;
                end
                CMD_SEARCH:
                begin
                    search_en = 1'b1;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (g == 0)
        begin : g_bottom
            assign lower = cell_data[g];
        end
        else
        begin : g_lower
            assign lower = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign upper = cell_data[g];
        end
        else
        begin : g_upper
            assign upper = cell_data[g+1];
        end

        olte_cell #(
            .IDX        (g),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .count (count_reg),
            .key   (key_reg),
            .lower (lower),
            .upper (upper),
            .data  (cell_data[g]),
            .match (match_vec[g]),
            .hit   (hit_vec[g])
        );
    end

    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit_vec[i])
                rd_sel = rd_sel | cell_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
            status_reg <= ST_OK;
            rd_reg     <= '0;
            match_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    state_reg <= accept ? S_EXEC : S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_EXEC)
            begin
                status_reg <= status_next;
                rd_reg     <= read_ok ? rd_sel : '0;
                match_reg  <= search_en ? match_vec : '0;
            end
            if (cfg_write && (paddr[2] == REG_CAPACITY))
            begin
                cap_reg   <= pwdata[CAP_W-1:0];
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item.command;
            pos_reg <= item.position;
            key_reg <= val_wide[DATA_WIDTH-1:0];
        end
    end

    // isolate lowest match, then encode its index
    assign first_hit = match_reg & (~match_reg + DEPTH'(1));

    always_comb
    begin
        fpos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            for (int b = 0; b < IDX_W; b++)
            begin
                if (((i >> b) & 1) == 1)
                    fpos[b] = fpos[b] | first_hit[i];
            end
        end
    end

    assign rd_wide   = 64'(rd_reg);
    assign fpos_wide = 64'(fpos);
    assign cnt_wide  = 64'(count_reg);

    assign done                  = state_reg == S_RESP;
    assign result.status         = status_reg;
    assign result.read_value     = rd_wide[VAL_W-1:0];
    assign result.found          = |match_reg;
    assign result.found_position = fpos_wide[POS_W-1:0];
    assign result.element_count  = cnt_wide[CAP_W-1:0];
    assign result.is_empty       = count_reg == '0;
    assign result.is_full        = cnt32 == eff_cap;

    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("command accepted without a result two cycles later");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt32 <= eff_cap || $past(cfg_write))
        else $error("element count above capacity");

    a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.found |-> result.status == ST_OK && result.read_value == '0)
        else $error("search hit with non-ok status or read data");

    a_no_done_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule
